[rtl/core/llsqf_pkg.sv]
package llsqf_pkg;

  // fit status codes
  localparam logic [1:0] FIT_OK       = 2'd0;
  localparam logic [1:0] FIT_SINGULAR = 2'd1;
  localparam logic [1:0] FIT_TOO_MANY = 2'd2;

  // ln(2) in unsigned Q0.32
  localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

  // saturation value of the reported sample count
  localparam logic [16:0] COUNT_OUT_MAX = 17'h1_FFFF;

  localparam int unsigned SUM_W  = 64;
  localparam int unsigned WIDE_W = 128;

  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [WIDE_W-1:0] wide_t;

endpackage

[rtl/core/log_log_least_squares_fit.sv]
// a non-last transaction keeps the block busy while it takes the two logarithms
// (normalize one bit a cycle, then 24 squarings on the shared 32x32 multiplier)
// a last transaction goes straight to the result on overflow; else it forms the fit terms and stops if they are
// singular; a valid fit takes nine 64x64 products, two 64-step square roots and two or three 128-step divides
// throughput: one transaction at a time; in_ready is high only while idle
// reset (rst_n low, synchronous): sums, count and flags cleared, threshold set to 1
module log_log_least_squares_fit import llsqf_pkg::*; #(
  parameter int MAX_ITEMS       = 65536,
  parameter int INPUT_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input transactions
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_x_value,
  input  logic [31:0] in_y_value,
  input  logic        in_last_item,
  // result transactions
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_fit_status,
  output logic [31:0] out_slope,
  output logic [31:0] out_intercept,
  output logic [31:0] out_correlation,
  output logic [16:0] out_sample_count,
  // threshold register write
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  // counter wide enough to hold MAX_ITEMS itself
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_ITEMS);
  localparam logic [16:0] SAT_FULL =
    (MAX_ITEMS > 131071) ? COUNT_OUT_MAX : 17'(MAX_ITEMS);

  localparam logic [6:0] SQ_LAST   = 7'd23;
  localparam logic [6:0] SQRT_LAST = 7'd63;
  localparam logic [6:0] DIV_LAST  = 7'd127;

  // divide jobs
  localparam logic [1:0] DIV_SLOPE = 2'd0;
  localparam logic [1:0] DIV_ICPT  = 2'd1;
  localparam logic [1:0] DIV_CORR  = 2'd2;

  // fit product program: even ops open a term, odd ops subtract and close it
  localparam logic [2:0] OP_D_NXX = 3'd0;
  localparam logic [2:0] OP_D_XX  = 3'd1;
  localparam logic [2:0] OP_E_NYY = 3'd2;
  localparam logic [2:0] OP_E_YY  = 3'd3;
  localparam logic [2:0] OP_A_NXY = 3'd4;
  localparam logic [2:0] OP_A_XY  = 3'd5;
  localparam logic [2:0] OP_B_YXX = 3'd6;
  localparam logic [2:0] OP_B_XXY = 3'd7;

  typedef enum logic [4:0] {
    S_IDLE, S_NORM, S_SQ, S_LN_PREP, S_LN_MUL, S_LN_RND,
    S_PRD_MUL, S_PRD_RND, S_ACC,
    S_MM_LOAD, S_MM, S_MM_DONE, S_MM_COMB, S_CHECK,
    S_SQRT_LOAD, S_SQRT, S_NORM96,
    S_DIV_LOAD, S_DIV_PREP, S_DIV, S_DIV_END, S_EMIT
  } state_t;

  state_t state_r;

  // configuration and accumulators
  logic [31:0]      thr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             ovf_r;
  sum_t             sx_r, sxx_r, sxy_r, sy_r, syy_r;

  // per transaction
  logic [31:0] yv_r;
  logic        last_r;
  logic        val_sel_r;
  logic [31:0] m_r;
  logic [4:0]  exp_r;
  logic [23:0] frac_r;
  logic [31:0] l2_mag_r;
  logic        l2_neg_r;
  logic [31:0] xl_r, yl_r;
  logic [1:0]  prd_idx_r;
  sum_t        pxx_r, pxy_r, pyy_r;
  logic [6:0]  step_r;
  logic [63:0] pp_r;

  // wide multiply
  logic [63:0] mm_a_r, mm_b_r;
  logic        mm_neg_r;
  logic [2:0]  mm_k_r;
  logic        mm_pctx_r;
  wide_t       mm_acc_r, prod_r, tmp_r;
  logic [2:0]  op_r;

  // fit terms
  wide_t dd_r, ee_r, aa_r, bb_r;

  // square root
  logic        sq_sel_r;
  wide_t       sq_v_r;
  logic [67:0] sq_rem_r;
  logic [63:0] sq_res_r;
  logic [63:0] sd_r;

  // correlation operands
  wide_t p_r, am_r;

  // divider
  logic [1:0] div_sel_r;
  wide_t      dv_n_r, dv_d_r, dvd_r, dvs_r, rem_r;
  logic       dv_neg_r;

  // fit results before the output register
  logic [1:0]  res_stat_r;
  logic [31:0] res_slope_r, res_icpt_r, res_corr_r;

  // output register
  logic        out_valid_r;
  logic [1:0]  out_stat_r;
  logic [31:0] out_slope_r, out_icpt_r, out_corr_r;
  logic [16:0] out_cnt_r;

  // shared 32x32 multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] xmag, ymag;

  assign xmag = xl_r[31] ? (32'd0 - xl_r) : xl_r;
  assign ymag = yl_r[31] ? (32'd0 - yl_r) : yl_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQ: begin
        mul_a = m_r;
        mul_b = m_r;
      end
      S_LN_MUL: begin
        mul_a = l2_mag_r;
        mul_b = LN2_Q32;
      end
      S_PRD_MUL: begin
        case (prd_idx_r)
          2'd0:    begin mul_a = xmag; mul_b = xmag; end
          2'd1:    begin mul_a = xmag; mul_b = ymag; end
          default: begin mul_a = ymag; mul_b = ymag; end
        endcase
      end
      S_MM: begin
        case (mm_k_r[1:0])
          2'd0:    begin mul_a = mm_a_r[31:0];  mul_b = mm_b_r[31:0];  end
          2'd1:    begin mul_a = mm_a_r[31:0];  mul_b = mm_b_r[63:32]; end
          2'd2:    begin mul_a = mm_a_r[63:32]; mul_b = mm_b_r[31:0];  end
          default: begin mul_a = mm_a_r[63:32]; mul_b = mm_b_r[63:32]; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // squaring step: m*m back to [1,2) in Q1.31, one log2 fraction bit out
  logic [32:0] sq_t;
  assign sq_t = mul_p[63:31];

  // log2 in Q8.24 from exponent and fraction
  logic [31:0] ediff, l2u;
  assign ediff = 32'(exp_r) - 32'(INPUT_FRAC_BITS);
  assign l2u   = {ediff[7:0], frac_r};

  // rounding of the ln product and of the squared terms
  logic [63:0] ln_sum, prd_sum, prd_mag;
  logic [31:0] ln_mag;
  logic        prd_neg;
  assign ln_sum  = pp_r + 64'h0000_0000_8000_0000;
  assign ln_mag  = ln_sum[63:32];
  assign prd_sum = pp_r + 64'h0000_0000_0080_0000;
  assign prd_mag = {24'd0, prd_sum[63:24]};
  assign prd_neg = (prd_idx_r == 2'd1) && (xl_r[31] ^ yl_r[31]);

  // fit program operand select
  sum_t nn_s;
  sum_t ld_a, ld_b;
  assign nn_s = SUM_W'(cnt_r);

  always_comb begin
    unique case (op_r)
      OP_D_NXX: begin ld_a = nn_s; ld_b = sxx_r; end
      OP_D_XX:  begin ld_a = sx_r; ld_b = sx_r;  end
      OP_E_NYY: begin ld_a = nn_s; ld_b = syy_r; end
      OP_E_YY:  begin ld_a = sy_r; ld_b = sy_r;  end
      OP_A_NXY: begin ld_a = nn_s; ld_b = sxy_r; end
      OP_A_XY:  begin ld_a = sx_r; ld_b = sy_r;  end
      OP_B_YXX: begin ld_a = sy_r; ld_b = sxx_r; end
      default:  begin ld_a = sx_r; ld_b = sxy_r; end
    endcase
  end

  // partial product placement
  wide_t pp_place;
  always_comb begin
    case (mm_k_r)
      3'd1:    pp_place = {64'd0, pp_r};
      3'd2:    pp_place = {32'd0, pp_r, 32'd0};
      3'd3:    pp_place = {32'd0, pp_r, 32'd0};
      default: pp_place = {pp_r, 64'd0};
    endcase
  end

  // singular check
  wide_t dmag, thr_w;
  logic  singular;
  assign dmag     = dd_r[127] ? (128'd0 - dd_r) : dd_r;
  assign thr_w    = {72'd0, thr_r, 24'd0};
  assign singular = (dd_r == '0) || (dmag < thr_w);

  // square root digit step
  logic [67:0] sq_rem_sh, sq_trial;
  logic        sq_ge;
  logic [63:0] sq_res_nxt;
  assign sq_rem_sh  = {sq_rem_r[65:0], sq_v_r[127:126]};
  assign sq_trial   = {2'd0, sq_res_r, 2'b01};
  assign sq_ge      = sq_rem_sh >= sq_trial;
  assign sq_res_nxt = {sq_res_r[62:0], sq_ge};

  // divide job setup
  wide_t dj_num, dj_den, dj_nmag, dj_dmag, dj_n;
  logic  dj_neg;
  always_comb begin
    dj_num = (div_sel_r == DIV_ICPT) ? bb_r : aa_r;
    dj_den = dd_r;
    if (div_sel_r == DIV_CORR) begin
      dj_nmag = am_r;
      dj_dmag = p_r;
      dj_neg  = aa_r[127] && (am_r != '0);
      dj_n    = am_r << 30;
    end else begin
      dj_nmag = dj_num[127] ? (128'd0 - dj_num) : dj_num;
      dj_dmag = dj_den[127] ? (128'd0 - dj_den) : dj_den;
      dj_neg  = dj_num[127] ^ dj_den[127];
      dj_n    = dj_nmag << 16;
    end
  end

  // restoring divide step
  wide_t dv_rsh;
  logic  dv_ge;
  assign dv_rsh = {rem_r[126:0], dvd_r[127]};
  assign dv_ge  = dv_rsh >= dvs_r;

  // quotient saturation
  logic [31:0] dq_lim, dq_mag, dq_res;
  always_comb begin
    if (div_sel_r == DIV_CORR) begin
      dq_lim = 32'h4000_0000;
    end else begin
      dq_lim = dv_neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    dq_mag = ((dvd_r[127:32] != '0) || (dvd_r[31:0] > dq_lim)) ? dq_lim : dvd_r[31:0];
    dq_res = dv_neg_r ? (32'd0 - dq_mag) : dq_mag;
  end

  // reported count, saturated
  logic [31:0] cnt32;
  logic [16:0] cnt_sat;
  assign cnt32   = 32'(cnt_r);
  assign cnt_sat = (cnt32 > 32'(COUNT_OUT_MAX)) ? COUNT_OUT_MAX : cnt32[16:0];

  logic full_now;
  assign full_now = cnt_r >= CNT_LIMIT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= 32'd1;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      sx_r        <= '0;
      sxx_r       <= '0;
      sxy_r       <= '0;
      sy_r        <= '0;
      syy_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      // S_EMIT reloads the output register itself
      if (out_valid_r && out_ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            yv_r      <= in_y_value;
            last_r    <= in_last_item;
            val_sel_r <= 1'b0;
            m_r       <= (in_x_value == '0) ? 32'd1 : in_x_value;
            exp_r     <= 5'd31;
            state_r   <= S_NORM;
          end
        end

        // bring the value to [1,2) one bit a cycle
        S_NORM: begin
          if (!m_r[31]) begin
            m_r   <= {m_r[30:0], 1'b0};
            exp_r <= exp_r - 5'd1;
          end else begin
            step_r  <= '0;
            frac_r  <= '0;
            state_r <= S_SQ;
          end
        end

        S_SQ: begin
          if (sq_t[32]) begin
            m_r    <= sq_t[32:1];
            frac_r <= {frac_r[22:0], 1'b1};
          end else begin
            m_r    <= sq_t[31:0];
            frac_r <= {frac_r[22:0], 1'b0};
          end
          step_r <= step_r + 7'd1;
          if (step_r == SQ_LAST) begin
            state_r <= S_LN_PREP;
          end
        end

        S_LN_PREP: begin
          l2_neg_r <= l2u[31];
          l2_mag_r <= l2u[31] ? (32'd0 - l2u) : l2u;
          state_r  <= S_LN_MUL;
        end

        S_LN_MUL: begin
          pp_r    <= mul_p;
          state_r <= S_LN_RND;
        end

        S_LN_RND: begin
          if (!val_sel_r) begin
            xl_r      <= l2_neg_r ? (32'd0 - ln_mag) : ln_mag;
            val_sel_r <= 1'b1;
            m_r       <= (yv_r == '0) ? 32'd1 : yv_r;
            exp_r     <= 5'd31;
            state_r   <= S_NORM;
          end else begin
            yl_r      <= l2_neg_r ? (32'd0 - ln_mag) : ln_mag;
            prd_idx_r <= 2'd0;
            state_r   <= S_PRD_MUL;
          end
        end

        S_PRD_MUL: begin
          pp_r    <= mul_p;
          state_r <= S_PRD_RND;
        end

        S_PRD_RND: begin
          case (prd_idx_r)
            2'd0:    pxx_r <= prd_mag;
            2'd1:    pxy_r <= prd_neg ? (64'd0 - prd_mag) : prd_mag;
            default: pyy_r <= prd_mag;
          endcase
          if (prd_idx_r == 2'd2) begin
            state_r <= S_ACC;
          end else begin
            prd_idx_r <= prd_idx_r + 2'd1;
            state_r   <= S_PRD_MUL;
          end
        end

        // add the transaction into the sums unless the set is full
        S_ACC: begin
          if (full_now) begin
            ovf_r <= 1'b1;
          end else begin
            sx_r  <= sx_r + {{32{xl_r[31]}}, xl_r};
            sy_r  <= sy_r + {{32{yl_r[31]}}, yl_r};
            sxx_r <= sxx_r + pxx_r;
            sxy_r <= sxy_r + pxy_r;
            syy_r <= syy_r + pyy_r;
            cnt_r <= cnt_r + CNT_W'(1);
          end
          if (!last_r) begin
            state_r <= S_IDLE;
          end else if (ovf_r || full_now) begin
            res_stat_r  <= FIT_TOO_MANY;
            res_slope_r <= '0;
            res_icpt_r  <= '0;
            res_corr_r  <= '0;
            state_r     <= S_EMIT;
          end else begin
            op_r    <= OP_D_NXX;
            state_r <= S_MM_LOAD;
          end
        end

        // signed 64x64 product as magnitudes and a sign
        S_MM_LOAD: begin
          mm_a_r    <= ld_a[63] ? (64'd0 - ld_a) : ld_a;
          mm_b_r    <= ld_b[63] ? (64'd0 - ld_b) : ld_b;
          mm_neg_r  <= ld_a[63] ^ ld_b[63];
          mm_acc_r  <= '0;
          mm_k_r    <= '0;
          mm_pctx_r <= 1'b0;
          state_r   <= S_MM;
        end

        // four partial products, each registered and added in the cycle after it is formed
        S_MM: begin
          if (mm_k_r != 3'd4) begin
            pp_r <= mul_p;
          end
          if (mm_k_r != 3'd0) begin
            mm_acc_r <= mm_acc_r + pp_place;
          end
          mm_k_r <= mm_k_r + 3'd1;
          if (mm_k_r == 3'd4) begin
            state_r <= S_MM_DONE;
          end
        end

        S_MM_DONE: begin
          prod_r  <= mm_neg_r ? (128'd0 - mm_acc_r) : mm_acc_r;
          state_r <= S_MM_COMB;
        end

        S_MM_COMB: begin
          if (mm_pctx_r) begin
            p_r     <= prod_r;
            am_r    <= aa_r[127] ? (128'd0 - aa_r) : aa_r;
            state_r <= S_NORM96;
          end else begin
            case (op_r) inside
              OP_D_NXX, OP_E_NYY, OP_A_NXY: tmp_r <= prod_r << 24;
              OP_B_YXX:                     tmp_r <= prod_r;
              OP_D_XX:                      dd_r  <= tmp_r - prod_r;
              OP_E_YY:                      ee_r  <= tmp_r - prod_r;
              OP_A_XY:                      aa_r  <= tmp_r - prod_r;
              default:                      bb_r  <= tmp_r - prod_r;
            endcase
            if (op_r == OP_B_XXY) begin
              state_r <= S_CHECK;
            end else begin
              op_r    <= op_r + 3'd1;
              state_r <= S_MM_LOAD;
            end
          end
        end

        S_CHECK: begin
          if (singular) begin
            res_stat_r  <= FIT_SINGULAR;
            res_slope_r <= '0;
            res_icpt_r  <= '0;
            res_corr_r  <= '0;
            state_r     <= S_EMIT;
          end else begin
            res_stat_r <= FIT_OK;
            sq_sel_r   <= 1'b0;
            state_r    <= S_SQRT_LOAD;
          end
        end

        // negative spread counts as zero under the root
        S_SQRT_LOAD: begin
          if (!sq_sel_r) begin
            sq_v_r <= dd_r[127] ? '0 : dd_r;
          end else begin
            sq_v_r <= ee_r[127] ? '0 : ee_r;
          end
          sq_rem_r <= '0;
          sq_res_r <= '0;
          step_r   <= '0;
          state_r  <= S_SQRT;
        end

        // two radicand bits per cycle, floor root
        S_SQRT: begin
          sq_rem_r <= sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
          sq_res_r <= sq_res_nxt;
          sq_v_r   <= {sq_v_r[125:0], 2'b00};
          step_r   <= step_r + 7'd1;
          if (step_r == SQRT_LAST) begin
            if (!sq_sel_r) begin
              sd_r     <= sq_res_nxt;
              sq_sel_r <= 1'b1;
              state_r  <= S_SQRT_LOAD;
            end else begin
              mm_a_r    <= sd_r;
              mm_b_r    <= sq_res_nxt;
              mm_neg_r  <= 1'b0;
              mm_acc_r  <= '0;
              mm_k_r    <= '0;
              mm_pctx_r <= 1'b1;
              state_r   <= S_MM;
            end
          end
        end

        // shift both correlation operands down until they fit in 96 bits
        S_NORM96: begin
          if ((p_r[127:96] != '0) || (am_r[127:96] != '0)) begin
            p_r  <= p_r >> 1;
            am_r <= am_r >> 1;
          end else begin
            div_sel_r <= DIV_SLOPE;
            state_r   <= S_DIV_LOAD;
          end
        end

        S_DIV_LOAD: begin
          dv_n_r   <= dj_n;
          dv_d_r   <= dj_dmag;
          dv_neg_r <= dj_neg;
          state_r  <= S_DIV_PREP;
        end

        // round to nearest: (2n + d) / (2d)
        S_DIV_PREP: begin
          dvd_r   <= {dv_n_r[126:0], 1'b0} + dv_d_r;
          dvs_r   <= {dv_d_r[126:0], 1'b0};
          rem_r   <= '0;
          step_r  <= '0;
          state_r <= S_DIV;
        end

        S_DIV: begin
          rem_r  <= dv_ge ? (dv_rsh - dvs_r) : dv_rsh;
          dvd_r  <= {dvd_r[126:0], dv_ge};
          step_r <= step_r + 7'd1;
          if (step_r == DIV_LAST) begin
            state_r <= S_DIV_END;
          end
        end

        S_DIV_END: begin
          unique case (div_sel_r)
            DIV_SLOPE: begin
              res_slope_r <= dq_res;
              div_sel_r   <= DIV_ICPT;
              state_r     <= S_DIV_LOAD;
            end
            DIV_ICPT: begin
              res_icpt_r <= dq_res;
              if (p_r == '0) begin
                res_corr_r <= '0;
                state_r    <= S_EMIT;
              end else begin
                div_sel_r <= DIV_CORR;
                state_r   <= S_DIV_LOAD;
              end
            end
            default: begin
              res_corr_r <= dq_res;
              state_r    <= S_EMIT;
            end
          endcase
        end

        // hand the result to the output register and clear the sums
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_stat_r  <= res_stat_r;
            out_slope_r <= res_slope_r;
            out_icpt_r  <= res_icpt_r;
            out_corr_r  <= res_corr_r;
            out_cnt_r   <= cnt_sat;
            cnt_r       <= '0;
            ovf_r       <= 1'b0;
            sx_r        <= '0;
            sxx_r       <= '0;
            sxy_r       <= '0;
            sy_r        <= '0;
            syy_r       <= '0;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_fit_status   = out_stat_r;
  assign out_slope        = out_slope_r;
  assign out_intercept    = out_icpt_r;
  assign out_correlation  = out_corr_r;
  assign out_sample_count = out_cnt_r;

  // a transaction blocks the input for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a transaction");

  // only a valid fit carries nonzero coefficients
  a_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_fit_status != FIT_OK)) |->
      ((out_slope == '0) && (out_intercept == '0) && (out_correlation == '0)))
    else $error("coefficients nonzero on a failed fit");

  // correlation clamped to [-1.0, +1.0]
  a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_fit_status == FIT_OK)) |->
      (($signed(out_correlation) <= 32'sh4000_0000) &&
       ($signed(out_correlation) >= -32'sh4000_0000)))
    else $error("correlation out of range");

  // an overflowed set always reports a full count
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_fit_status == FIT_TOO_MANY)) |-> (out_sample_count == SAT_FULL))
    else $error("overflow reported with a short count");

endmodule
